FILE: hw/rtl/stk_pkg.sv
// Shared types and constants of the script tokenizer.
// No dependencies; compile first.
package stk_pkg;

  // Field widths
  localparam int ByteW = 8;
  localparam int LenW  = 16;
  localparam int KindW = 2;

  // Register reset value of the token length limit
  localparam logic [LenW-1:0] MaxLenReset = 16'd1024;

  // Character codes the scanner looks for
  localparam logic [ByteW-1:0] CharNul   = 8'h00;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharQuote = 8'h22;
  localparam logic [ByteW-1:0] CharStar  = 8'h2a;
  localparam logic [ByteW-1:0] CharSlash = 8'h2f;
  localparam logic [ByteW-1:0] CharNl    = 8'h0a;

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KIND_CHAR     = 2'd0,
    KIND_END      = 2'd1,
    KIND_DATA_END = 2'd2
  } kind_e;

  // One result item
  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] char_out;
    logic [LenW-1:0]  token_length;
    logic             was_quoted;
    logic             overflowed;
    logic             last;
  } result_t;

endpackage

FILE: hw/rtl/stk_if.sv
// Stream interfaces of the script tokenizer: text bytes in, results out,
// and the limit register write channel. Depends on stk_pkg.
interface stk_text_if;
  logic                      valid;
  logic                      ready;
  logic [stk_pkg::ByteW-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface stk_tok_if;
  logic                      valid;
  logic                      ready;
  logic [stk_pkg::KindW-1:0] kind;
  logic [stk_pkg::ByteW-1:0] char_out;
  logic [stk_pkg::LenW-1:0]  token_length;
  logic                      was_quoted;
  logic                      overflowed;
  logic                      last;

  modport source (output valid, output kind, output char_out, output token_length,
                  output was_quoted, output overflowed, output last, input ready);
  modport sink   (input valid, input kind, input char_out, input token_length,
                  input was_quoted, input overflowed, input last, output ready);
endinterface

interface stk_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [stk_pkg::LenW-1:0] wdata;

  modport source (output valid, output wdata, input ready);
  modport sink   (input valid, input wdata, output ready);
endinterface

FILE: hw/rtl/script_tokenizer_core.sv
// Script tokenizer top level: scanner state machine and result queue.
// Depends on stk_pkg and the interfaces in stk_if.sv.
//
// Takes one text byte per cycle while text ready is high and streams out
// token characters, token-end results (length, quoted and overflow flags)
// and an end-of-buffer result on a NUL byte. Each byte is scanned in the
// cycle it is transferred and its zero to three results go at once into a
// four-entry result queue; the result channel moves one result per cycle
// while result ready is high. Some bytes make two or three results (a lone
// slash closing a word, a NUL ending a token). Text ready is high while
// the queue holds at most one result, so a stalled result side holds the
// text side once two or more results wait. The limit register is written
// over its own channel, which is always ready, and should only be written
// while the block is idle.
module script_tokenizer_core (
  input  logic    clk_i,
  input  logic    rst_ni,
  stk_text_if.sink  text_i,
  stk_tok_if.source tok_o,
  stk_cfg_if.sink   cfg_i
);
  import stk_pkg::*;

  // Scanner modes
  localparam logic [2:0] ModeBetween = 3'd0;
  localparam logic [2:0] ModeSlash   = 3'd1;
  localparam logic [2:0] ModeLine    = 3'd2;
  localparam logic [2:0] ModeBlock   = 3'd3;
  localparam logic [2:0] ModeStar    = 3'd4;
  localparam logic [2:0] ModeWord    = 3'd5;
  localparam logic [2:0] ModeQuote   = 3'd6;

  // Result queue geometry
  localparam int Depth  = 4;
  localparam int MaxRes = 3;
  localparam int PtrW   = $clog2(Depth);
  localparam int FillW  = $clog2(Depth + 1);
  localparam int NResW  = $clog2(MaxRes + 1);

  function automatic result_t mk_char(logic [ByteW-1:0] ch);
    result_t r;
    r          = '0;
    r.kind     = KIND_CHAR;
    r.char_out = ch;
    return r;
  endfunction

  function automatic result_t mk_end(logic [LenW-1:0] len, logic quoted, logic ov);
    result_t r;
    r              = '0;
    r.kind         = KIND_END;
    r.token_length = len;
    r.was_quoted   = quoted;
    r.overflowed   = ov;
    return r;
  endfunction

  function automatic result_t mk_data_end();
    result_t r;
    r      = '0;
    r.kind = KIND_DATA_END;
    return r;
  endfunction

  logic [2:0]       mode_q, mode_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [LenW-1:0]  max_len_q;
  result_t          ent_q [Depth];
  logic [PtrW-1:0]  rd_ptr_q, wr_ptr_q;
  logic [FillW-1:0] fill_q;

  result_t          res [Depth];
  logic [NResW-1:0] n_res;
  logic [ByteW-1:0] b;
  logic             word_b;
  logic             push, pop;

  assign b      = text_i.text_byte;
  assign word_b = (b > CharSpace) && !b[ByteW-1];

  // Limit register write
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.wdata;
    end
  end

  // Scan one byte: next mode, next count and the results it makes
  always_comb begin
    logic [LenW-1:0] c;
    mode_d = mode_q;
    c      = cnt_q;
    n_res  = '0;
    for (int i = 0; i < Depth; i++) begin
      res[i] = '0;
    end
    unique case (mode_q)
      ModeSlash: begin
        if (b == CharSlash) begin
          mode_d = ModeLine;
        end else if (b == CharStar) begin
          mode_d = ModeBlock;
        end else begin
          // lone slash opens a word, the byte then goes through the word rules
          mode_d = ModeWord;
          c      = '0;
          if (c < max_len_q) begin
            res[n_res[PtrW-1:0]] = mk_char(CharSlash);
            n_res                = n_res + 1'b1;
            c                    = c + 1'b1;
          end
          if (word_b) begin
            if (c < max_len_q) begin
              res[n_res[PtrW-1:0]] = mk_char(b);
              n_res                = n_res + 1'b1;
              c                    = c + 1'b1;
            end
          end else begin
            res[n_res[PtrW-1:0]] = mk_end(c, 1'b0, c >= max_len_q);
            n_res                = n_res + 1'b1;
            c                    = '0;
            mode_d               = ModeBetween;
            if (b == CharNul) begin
              res[n_res[PtrW-1:0]] = mk_data_end();
              n_res                = n_res + 1'b1;
            end
          end
        end
      end
      ModeLine: begin
        if (b == CharNul) begin
          res[0] = mk_data_end();
          n_res  = NResW'(1);
          c      = '0;
          mode_d = ModeBetween;
        end else if (b == CharNl) begin
          mode_d = ModeBetween;
        end
      end
      ModeBlock: begin
        if (b == CharNul) begin
          res[0] = mk_data_end();
          n_res  = NResW'(1);
          c      = '0;
          mode_d = ModeBetween;
        end else if (b == CharStar) begin
          mode_d = ModeStar;
        end
      end
      ModeStar: begin
        if (b == CharNul) begin
          res[0] = mk_data_end();
          n_res  = NResW'(1);
          c      = '0;
          mode_d = ModeBetween;
        end else if (b == CharSlash) begin
          mode_d = ModeBetween;
        end else if (b != CharStar) begin
          mode_d = ModeBlock;
        end
      end
      ModeWord: begin
        if (word_b) begin
          if (c < max_len_q) begin
            res[0] = mk_char(b);
            n_res  = NResW'(1);
            c      = c + 1'b1;
          end
        end else begin
          res[0] = mk_end(c, 1'b0, c >= max_len_q);
          n_res  = NResW'(1);
          c      = '0;
          mode_d = ModeBetween;
          if (b == CharNul) begin
            res[1] = mk_data_end();
            n_res  = NResW'(2);
          end
        end
      end
      ModeQuote: begin
        if (b == CharQuote || b == CharNul) begin
          res[0] = mk_end(c, 1'b1, c >= max_len_q);
          n_res  = NResW'(1);
          c      = '0;
          mode_d = ModeBetween;
          if (b == CharNul) begin
            res[1] = mk_data_end();
            n_res  = NResW'(2);
          end
        end else if (c < max_len_q) begin
          res[0] = mk_char(b);
          n_res  = NResW'(1);
          c      = c + 1'b1;
        end
      end
      default: begin
        // between tokens; the unused mode code lands here too
        if (b == CharNul) begin
          res[0] = mk_data_end();
          n_res  = NResW'(1);
          c      = '0;
          mode_d = ModeBetween;
        end else if (!word_b) begin
          mode_d = ModeBetween;
        end else if (b == CharSlash) begin
          mode_d = ModeSlash;
        end else if (b == CharQuote) begin
          c      = '0;
          mode_d = ModeQuote;
        end else begin
          c      = '0;
          mode_d = ModeWord;
          if (c < max_len_q) begin
            res[0] = mk_char(b);
            n_res  = NResW'(1);
            c      = c + 1'b1;
          end
        end
      end
    endcase
    // flag the final result of this byte
    for (int i = 0; i < MaxRes; i++) begin
      if (NResW'(i + 1) == n_res) begin
        res[i].last = 1'b1;
      end
    end
    cnt_d = c;
  end

  // Handshakes
  assign text_i.ready = (fill_q <= FillW'(Depth - MaxRes));
  assign push         = text_i.valid && text_i.ready;
  assign pop          = tok_o.valid && tok_o.ready;

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeBetween;
      cnt_q  <= '0;
    end else if (push) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // Result queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fill_q <= fill_q + (push ? FillW'(n_res) : FillW'(0)) - (pop ? FillW'(1) : FillW'(0));
    end
  end

  // Result queue storage: all results of a byte land in one transfer
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      logic [PtrW-1:0] off;
      off = PtrW'(i) - wr_ptr_q;
      if (push && (NResW'(off) < n_res)) begin
        ent_q[i] <= res[off];
      end
    end
  end

  // Result channel
  assign tok_o.valid        = (fill_q != '0);
  assign tok_o.kind         = ent_q[rd_ptr_q].kind;
  assign tok_o.char_out     = ent_q[rd_ptr_q].char_out;
  assign tok_o.token_length = ent_q[rd_ptr_q].token_length;
  assign tok_o.was_quoted   = ent_q[rd_ptr_q].was_quoted;
  assign tok_o.overflowed   = ent_q[rd_ptr_q].overflowed;
  assign tok_o.last         = ent_q[rd_ptr_q].last;

endmodule

FILE: hw/rtl/stk_checker.sv
// Port-level checks of the script tokenizer, bound to the top level.
// Depends on stk_pkg and script_tokenizer_core.
module stk_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [stk_pkg::KindW-1:0] kind_i,
  input logic [stk_pkg::ByteW-1:0] char_out_i,
  input logic [stk_pkg::LenW-1:0]  token_length_i,
  input logic                      was_quoted_i,
  input logic                      overflowed_i,
  input logic                      last_i
);
  import stk_pkg::*;

  // Results of one byte are queued together, so the rest follow at once
  a_burst_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("results of one byte not contiguous");

  // End of buffer is always the final result of its byte
  a_data_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_DATA_END) |-> last_i)
    else $error("end-of-buffer result not flagged last");

  // Only token characters carry a character
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KIND_CHAR) |-> (char_out_i == '0))
    else $error("non-character result carries a character");

  // Length and flags only on token end
  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KIND_END)
      |-> (token_length_i == '0) && !was_quoted_i && !overflowed_i)
    else $error("token-end fields set on another kind");

endmodule

bind script_tokenizer_core stk_checker u_stk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (tok_o.valid),
  .out_ready_i    (tok_o.ready),
  .kind_i         (tok_o.kind),
  .char_out_i     (tok_o.char_out),
  .token_length_i (tok_o.token_length),
  .was_quoted_i   (tok_o.was_quoted),
  .overflowed_i   (tok_o.overflowed),
  .last_i         (tok_o.last)
);

FILE: tb/stk_checker.sv
// Scoreboard for script_tokenizer_core: watches the text, result and limit
// channels, predicts the result stream and compares it field by field.
// Depends on stk_pkg and the interfaces in stk_if.sv.
module stk_scoreboard (
  input  logic  clk_i,
  input  logic  rst_ni,
  stk_text_if   text_i,
  stk_tok_if    tok_i,
  stk_cfg_if    cfg_i,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import stk_pkg::*;

  // Scanner modes of the predictor
  typedef enum logic [2:0] {
    SC_BETWEEN, SC_SLASH, SC_LINE, SC_BLOCK, SC_STAR, SC_WORD, SC_QUOTE
  } scan_mode_e;

  scan_mode_e      scan_mode;
  logic [LenW-1:0] kept_count;
  logic [LenW-1:0] len_limit;
  result_t         token_q[$];

  function automatic void push_result(kind_e k, logic [ByteW-1:0] ch,
                                      logic [LenW-1:0] len, logic quoted, logic ovf);
    result_t r;
    r.kind         = k;
    r.char_out     = ch;
    r.token_length = len;
    r.was_quoted   = quoted;
    r.overflowed   = ovf;
    r.last         = 1'b0;
    token_q.push_back(r);
  endfunction

  // Characters past the limit are dropped silently
  function automatic void keep_char(logic [ByteW-1:0] ch);
    if (kept_count < len_limit) begin
      push_result(KIND_CHAR, ch, '0, 1'b0, 1'b0);
      kept_count++;
    end
  endfunction

  function automatic void close_token(logic quoted);
    push_result(KIND_END, '0, kept_count, quoted, kept_count >= len_limit);
    kept_count = '0;
    scan_mode  = SC_BETWEEN;
  endfunction

  function automatic void close_buffer();
    push_result(KIND_DATA_END, '0, '0, 1'b0, 1'b0);
    kept_count = '0;
    scan_mode  = SC_BETWEEN;
  endfunction

  // 7-bit bytes above space belong to a word
  function automatic logic is_word_byte(logic [ByteW-1:0] b);
    return !b[ByteW-1] && (b > CharSpace);
  endfunction

  function automatic void word_step(logic [ByteW-1:0] b);
    if (is_word_byte(b)) begin
      keep_char(b);
    end else begin
      close_token(1'b0);
      if (b == CharNul) close_buffer();
    end
  endfunction

  // One text byte through the scanner; tags the final result of the burst
  function automatic void scan_byte(logic [ByteW-1:0] b);
    int n_prior;
    n_prior = token_q.size();
    case (scan_mode)
      SC_SLASH: begin
        if (b == CharSlash) scan_mode = SC_LINE;
        else if (b == CharStar) scan_mode = SC_BLOCK;
        else begin
          // lone slash opens a word, then this byte is part of it
          kept_count = '0;
          scan_mode  = SC_WORD;
          keep_char(CharSlash);
          word_step(b);
        end
      end
      SC_LINE: begin
        if (b == CharNul) close_buffer();
        else if (b == CharNl) scan_mode = SC_BETWEEN;
      end
      SC_BLOCK: begin
        if (b == CharNul) close_buffer();
        else if (b == CharStar) scan_mode = SC_STAR;
      end
      SC_STAR: begin
        if (b == CharNul) close_buffer();
        else if (b == CharSlash) scan_mode = SC_BETWEEN;
        else if (b != CharStar) scan_mode = SC_BLOCK;
      end
      SC_WORD: word_step(b);
      SC_QUOTE: begin
        if (b == CharQuote) close_token(1'b1);
        else if (b == CharNul) begin
          close_token(1'b1);
          close_buffer();
        end else keep_char(b);
      end
      default: begin
        if (b == CharNul) close_buffer();
        else if (!is_word_byte(b)) begin
          // skipped between tokens
        end else if (b == CharSlash) scan_mode = SC_SLASH;
        else if (b == CharQuote) begin
          kept_count = '0;
          scan_mode  = SC_QUOTE;
        end else begin
          kept_count = '0;
          scan_mode  = SC_WORD;
          keep_char(b);
        end
      end
    endcase
    if (token_q.size() > n_prior) token_q[token_q.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [LenW-1:0] want,
                                      logic [LenW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (token_q.size() == 0) begin
      $error("kind: expected no result, actual %0d", tok_i.kind);
      fail_count_o++;
      return;
    end
    want = token_q.pop_front();
    check_field("kind", LenW'(want.kind), LenW'(tok_i.kind));
    check_field("char_out", LenW'(want.char_out), LenW'(tok_i.char_out));
    check_field("token_length", want.token_length, tok_i.token_length);
    check_field("was_quoted", LenW'(want.was_quoted), LenW'(tok_i.was_quoted));
    check_field("overflowed", LenW'(want.overflowed), LenW'(tok_i.overflowed));
    check_field("last", LenW'(want.last), LenW'(tok_i.last));
  endfunction

  // Results are compared before the byte of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode    = SC_BETWEEN;
      kept_count   = '0;
      len_limit    = MaxLenReset;
      token_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (tok_i.valid && tok_i.ready) check_result();
      if (cfg_i.valid && cfg_i.ready) len_limit = cfg_i.wdata;
      if (text_i.valid && text_i.ready) scan_byte(text_i.text_byte);
      pending_o = token_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Top of the script_tokenizer_core testbench: clock, reset, text and limit
// stimulus, random result back-pressure and the verdict.
// Depends on stk_pkg, stk_if.sv, the core and tb/stk_checker.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stk_pkg::*;

  // Opening text: byte range edges, lone slash, comments, NUL in word, quote and block modes
  localparam logic [ByteW-1:0] OpeningText [23] = '{
    8'h80, CharSpace, 8'h21, 8'h7f, 8'hff,
    CharSlash, 8'h78, CharNul,
    CharSlash, CharStar, CharSlash, CharStar, CharSlash,
    CharSlash, CharSlash, 8'h71, CharNl,
    CharQuote, CharSpace, CharNul,
    CharSlash, CharStar, CharNul
  };

  logic clk;
  logic rst_n;
  bit   idle_en;
  int   chk_fails;
  int   chk_pending;
  int   bytes_sent;

  stk_text_if text_if ();
  stk_tok_if  tok_if ();
  stk_cfg_if  cfg_if ();

  script_tokenizer_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .text_i (text_if),
    .tok_o  (tok_if),
    .cfg_i  (cfg_if)
  );

  stk_scoreboard u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .text_i       (text_if),
    .tok_i        (tok_if),
    .cfg_i        (cfg_if),
    .fail_count_o (chk_fails),
    .pending_o    (chk_pending)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("** script_tokenizer_core: FAILED **");
    $finish;
  end

  // Result side back-pressure, changed on the falling edge
  initial begin
    tok_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      tok_if.ready <= !idle_en || ($urandom_range(0, 99) >= 30);
    end
  end

  // Called on a falling edge; returns on the falling edge after the transfer
  task automatic send_byte(logic [ByteW-1:0] b);
    while (idle_en && $urandom_range(0, 99) < 30) begin
      text_if.valid <= 1'b0;
      @(negedge clk);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold the text side until every expected result is out, then settle
  task automatic drain_results();
    text_if.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [LenW-1:0] v);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.wdata <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly well-formed pieces of script text, with some raw noise
  task automatic send_random_piece();
    int               pick;
    int               n;
    logic [ByteW-1:0] b;
    pick = $urandom_range(0, 99);
    n    = $urandom_range(0, 6);
    if (pick < 30) begin
      // plain word
      for (int i = 0; i <= n; i++) send_byte(ByteW'($urandom_range(8'h21, 8'h7f)));
    end else if (pick < 50) begin
      // whitespace run, low control bytes or high half
      for (int i = 0; i <= n % 3; i++) begin
        if ($urandom_range(0, 1)) b = ByteW'($urandom_range(1, 8'h20));
        else b = ByteW'($urandom_range(8'h80, 8'hff));
        send_byte(b);
      end
    end else if (pick < 65) begin
      // quoted token, any non-NUL content
      send_byte(CharQuote);
      for (int i = 0; i < n; i++) begin
        b = ByteW'($urandom_range(1, 8'hff));
        send_byte(b == CharQuote ? CharSpace : b);
      end
      send_byte(CharQuote);
    end else if (pick < 73) begin
      // line comment
      send_byte(CharSlash);
      send_byte(CharSlash);
      for (int i = 0; i < n; i++) begin
        b = ByteW'($urandom_range(1, 8'hff));
        send_byte(b == CharNl ? CharStar : b);
      end
      send_byte(CharNl);
    end else if (pick < 83) begin
      // block comment with stray stars and slashes
      send_byte(CharSlash);
      send_byte(CharStar);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0:       b = CharStar;
          1:       b = CharSlash;
          default: b = ByteW'($urandom_range(1, 8'hff));
        endcase
        send_byte(b);
      end
      send_byte(CharStar);
      send_byte(CharSlash);
    end else if (pick < 90) begin
      send_byte(CharNul);
    end else begin
      send_byte(ByteW'($urandom_range(0, 8'hff)));
    end
  endtask

  task automatic run_phase(int n);
    int start_count;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n) send_random_piece();
  endtask

  // Stimulus and verdict
  initial begin
    rst_n             = 1'b0;
    idle_en           = 1'b1;
    bytes_sent        = 0;
    text_if.valid     = 1'b0;
    text_if.text_byte = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.wdata      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (OpeningText[i]) send_byte(OpeningText[i]);
    run_phase(10);

    // limit lowered below the count of an open word
    send_string("abc");
    write_limit(16'd2);
    send_string("d ");
    run_phase(8);

    write_limit(16'd0);
    run_phase(8);

    write_limit(16'd1);
    run_phase(8);

    // long stretch with both sides flat out
    idle_en = 1'b0;
    write_limit(16'hffff);
    run_phase(20);
    idle_en = 1'b1;

    write_limit(LenW'($urandom_range(3, 12)));
    run_phase(8);

    drain_results();
    repeat (8) @(negedge clk);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("** script_tokenizer_core: PASSED **");
    end else begin
      $display("** script_tokenizer_core: FAILED **");
    end
    $finish;
  end

endmodule
